@@ hdl/spd_pkg.sv @@
`default_nettype none

package spd_pkg;

   // character codes
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // results one input byte can release
   localparam int unsigned MAX_RES  = 3;
   localparam int unsigned CNT_W    = $clog2(MAX_RES + 1);
   localparam int unsigned IDX_W    = $clog2(MAX_RES);

   // bundle queue between front and back
   localparam int unsigned QDEPTH   = 4;
   localparam int unsigned QPTR_W   = $clog2(QDEPTH);
   localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   // all result bytes of one input byte
   typedef struct packed {
      logic [MAX_RES-1:0][7:0] bytes;
      logic [CNT_W-1:0]        count;
      logic                    last;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bnd;
   } push_type;

   typedef struct packed {
      logic       valid;
      bundle_type bnd;
   } head_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   // letters have low nibble 1..6, so value is nibble plus nine
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      if (c <= 8'h39) begin
         v = c[3:0];
      end else begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

   function automatic logic is_safe(input logic [7:0] v);
      return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h61 && v <= 8'd122) ||
             (v >= 8'h41 && v <= 8'h5A) || v == 8'h21 || v == 8'h24 ||
             v == 8'h26 || (v >= 8'h27 && v <= 8'h2f) || v == 8'h3A ||
             v == 8'h3B || v == 8'h3D || v == 8'h3f || v == 8'h40 ||
             v == 8'h5f;
   endfunction

endpackage

`default_nettype wire

@@ hdl/spd_front.sv @@
`default_nettype none

module spd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire logic [7:0]      req_in_byte,
   input  wire logic            req_last,
   input  wire logic            q_full,
   output logic                 full,
   output spd_pkg::push_type    q_push
);
   import spd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [7:0]             digit_ff, digit_in;
   bundle_type             bnd;
   logic [CNT_W-1:0]       n;
   logic                   accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   // classify the byte and build its result bundle
   always_comb begin
      bnd      = '0;
      n        = '0;
      phase_in = phase_ff;
      digit_in = digit_ff;
      unique case (phase_ff)
         PH_PCT: begin
            if (is_hex(req_in_byte)) begin
               digit_in = req_in_byte;
               phase_in = PH_DIGIT;
            end else begin
               bnd.bytes[n[IDX_W-1:0]] = CH_PCT;
               n = n + 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_DIGIT: begin
            phase_in = PH_IDLE;
            if (is_hex(req_in_byte)) begin
               if (!is_safe({hex_val(digit_ff), hex_val(req_in_byte)})) begin
                  bnd.bytes[n[IDX_W-1:0]] = {hex_val(digit_ff), hex_val(req_in_byte)};
                  n = n + 1'b1;
               end else begin
                  bnd.bytes[n[IDX_W-1:0]] = CH_PCT;
                  n = n + 1'b1;
                  bnd.bytes[n[IDX_W-1:0]] = digit_ff;
                  n = n + 1'b1;
                  bnd.bytes[n[IDX_W-1:0]] = req_in_byte;
                  n = n + 1'b1;
               end
            end else begin
               bnd.bytes[n[IDX_W-1:0]] = CH_PCT;
               n = n + 1'b1;
               bnd.bytes[n[IDX_W-1:0]] = digit_ff;
               n = n + 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // byte handled from idle, also after a broken escape
      if (phase_in == PH_IDLE && !(phase_ff == PH_DIGIT && is_hex(req_in_byte))) begin
         if (req_in_byte == CH_PCT) begin
            phase_in = PH_PCT;
         end else begin
            bnd.bytes[n[IDX_W-1:0]] = (req_in_byte == CH_PLUS) ? CH_SPACE : req_in_byte;
            n = n + 1'b1;
         end
      end

      // end of text flushes a pending escape
      if (req_last) begin
         if (phase_in == PH_PCT || phase_in == PH_DIGIT) begin
            bnd.bytes[n[IDX_W-1:0]] = CH_PCT;
            n = n + 1'b1;
         end
         if (phase_in == PH_DIGIT) begin
            bnd.bytes[n[IDX_W-1:0]] = digit_in;
            n = n + 1'b1;
         end
         phase_in = PH_IDLE;
      end

      bnd.count = n;
      bnd.last  = req_last;
   end

   // bundle transfer into the queue
   always_comb begin
      q_push.valid = accept && (n != '0);
      q_push.bnd   = bnd;
   end

   // escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         digit_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         digit_ff <= digit_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/spd_queue.sv @@
`default_nettype none

module spd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  spd_pkg::push_type    q_push,
   input  wire logic            q_pop,
   output logic                 q_full,
   output spd_pkg::head_type    q_head
);
   import spd_pkg::*;

   bundle_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 do_pop;

   assign q_full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_head.valid = (cnt_ff != '0);
   assign q_head.bnd   = slot_ff[rd_ptr_ff];
   assign do_pop       = q_pop && q_head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(q_push.valid) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         slot_ff[wr_ptr_ff] <= q_push.bnd;
      end
   end

endmodule

`default_nettype wire

@@ hdl/spd_back.sv @@
`default_nettype none

module spd_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  spd_pkg::head_type    q_head,
   output logic                 q_pop,
   input  wire logic            pop,
   output logic                 empty,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_text_end
);
   import spd_pkg::*;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff;
   logic               run_last_ff;
   logic               text_end_ff;
   logic               take;
   logic               final_one;

   assign empty        = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_text_end = text_end_ff;

   // move one byte of the head bundle into the output register
   always_comb begin
      take         = q_head.valid && (!out_valid_ff || pop);
      final_one    = (CNT_W'(idx_ff) + 1'b1) == q_head.bnd.count;
      q_pop        = take && final_one;
      idx_in       = idx_ff;
      if (take) begin
         idx_in = final_one ? '0 : idx_ff + 1'b1;
      end
      out_valid_in = take || (out_valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff <= q_head.bnd.bytes[idx_ff];
         run_last_ff <= final_one;
         text_end_ff <= final_one && q_head.bnd.last;
      end
   end

endmodule

`default_nettype wire

@@ hdl/selective_percent_decoder.sv @@
`default_nettype none

// Streaming URL percent decoder. Encoded text enters one byte per push; a plus
// sign becomes a space, and a percent escape with two hex digits is decoded
// only when its value is not a digit, letter or safe symbol, otherwise the
// three characters pass through as they are. An escape left open when a byte
// with req_last arrives is flushed as literal bytes. Each input byte releases
// zero to three result bytes; rsp_run_last marks the final byte of each
// input, rsp_text_end the final byte of the text. The front accepts one byte
// every cycle while the queue is not full and stores its results as one
// bundle in a four-entry queue; the back sends one result byte per cycle
// while results wait and pop takes each shown byte, so the result port sets
// the sustained rate. The first result of an input is written into the queue
// and then into the output register before it is shown.
module selective_percent_decoder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   req_in_byte,
   input  wire logic         req_last,
   output logic              empty,
   input  wire logic         pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_text_end
);
   import spd_pkg::*;

   push_type   q_push;
   head_type   q_head;
   logic       q_full;
   logic       q_pop;

   // classification
   spd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_in_byte (req_in_byte),
      .req_last    (req_last),
      .q_full      (q_full),
      .full        (full),
      .q_push      (q_push)
   );

   // bundle queue
   spd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   // result sequencing
   spd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_text_end (rsp_text_end)
   );

endmodule

`default_nettype wire

@@ hdl/spd_checker.sv @@
`default_nettype none

module spd_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         full,
   input  wire logic         empty,
   input  wire logic         pop,
   input  wire logic [7:0]   rsp_out_byte,
   input  wire logic         rsp_run_last,
   input  wire logic         rsp_text_end
);

   // nothing to show right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   // room for input right after reset
   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("full right after reset");

   // end of text only on the last byte of an input
   a_end_on_run_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_text_end) |-> rsp_run_last)
      else $error("text end without run last");

   // a waiting result is not withdrawn
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("waiting result withdrawn");

   // a waiting result does not change
   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_out_byte) && $stable(rsp_run_last) &&
                            $stable(rsp_text_end)))
      else $error("waiting result changed");

endmodule

bind selective_percent_decoder spd_checker u_spd_checker (
   .clock        (clock),
   .reset        (reset),
   .full         (full),
   .empty        (empty),
   .pop          (pop),
   .rsp_out_byte (rsp_out_byte),
   .rsp_run_last (rsp_run_last),
   .rsp_text_end (rsp_text_end)
);

`default_nettype wire
